// ----- rtl/core/hrf_pkg.sv -----
// Shared types, constants and decode functions of the hex reply frame checker.
package hrf_pkg;

    localparam int LINE_CHARS_DEF = 64;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] CKS_TARGET = 8'h55;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_COLON  = 3'd1;
    localparam logic [2:0] ST_BAD_CKS   = 3'd2;
    localparam logic [2:0] ST_WRONG_RSP = 3'd3;
    localparam logic [2:0] ST_OVERLONG  = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [3:0] sent_command;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] byte_value;
        logic [6:0] byte_index;
        logic [2:0] status;
        logic [7:0] frame_bytes;
        logic       is_final;
    } out_item_t;

    // Write strobes from the frame decoder into the result queue.
    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } push_ctl_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic logic [7:0] expected_code(input logic [3:0] sent);
        logic [7:0] e;
        case (sent)
            4'd1:       e = 8'd5;
            4'd3, 4'd4: e = 8'd1;
            default:    e = {4'd0, sent};
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/core/hrf_frame_decode.sv -----
// Frame state and per-character decode: pairs nibbles into bytes and builds the verdict.
module hrf_frame_decode #(
    parameter int LINE_CHARS = hrf_pkg::LINE_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  hrf_pkg::in_item_t item,
    output hrf_pkg::push_ctl_t push,
    output hrf_pkg::out_item_t first_result,
    output hrf_pkg::out_item_t second_result
);
    import hrf_pkg::*;

    logic       in_frame_reg,  in_frame_next;
    logic       colon_reg,     colon_next;
    logic       pending_reg,   pending_next;
    logic [3:0] held_reg,      held_next;
    logic [7:0] sum_reg,       sum_next;
    logic [7:0] first_reg,     first_next;
    logic [7:0] count_reg,     count_next;
    logic       overlong_reg,  overlong_next;

    logic       fresh;
    logic       cur_pending;
    logic [3:0] cur_held;
    logic [7:0] cur_sum;
    logic [7:0] cur_first;
    logic [7:0] cur_count;
    logic       cur_overlong;
    logic [8:0] pos;
    logic       drop;
    logic [3:0] nib;
    logic [7:0] byte_val;
    logic       byte_done;
    logic [2:0] status;
    out_item_t  byte_item;
    out_item_t  verdict_item;

    always_comb
    begin
        // The first character of a line starts from a cleared frame.
        fresh        = !in_frame_reg;
        cur_pending  = fresh ? 1'b0 : pending_reg;
        cur_held     = fresh ? 4'd0 : held_reg;
        cur_sum      = fresh ? 8'd0 : sum_reg;
        cur_first    = fresh ? 8'd0 : first_reg;
        cur_count    = fresh ? 8'd0 : count_reg;
        cur_overlong = fresh ? 1'b0 : overlong_reg;
        colon_next   = fresh ? (item.character == COLON_CHAR) : colon_reg;

        pos       = {cur_count, 1'b0} + {8'd0, cur_pending};
        drop      = cur_overlong || (pos >= 9'(LINE_CHARS));
        nib       = hex_value(item.character);
        byte_val  = {cur_held, nib};
        byte_done = !drop && cur_pending;

        overlong_next = cur_overlong || drop;
        held_next     = (!drop && !cur_pending) ? nib : cur_held;
        pending_next  = drop ? cur_pending : !cur_pending;
        sum_next      = byte_done ? cur_sum + byte_val : cur_sum;
        first_next    = (byte_done && cur_count == 8'd0) ? byte_val : cur_first;
        count_next    = byte_done ? cur_count + 8'd1 : cur_count;
        in_frame_next = !item.last;

        if (!colon_next) begin
            status = ST_NO_COLON;
        end else if (overlong_next) begin
            status = ST_OVERLONG;
        end else if (sum_next != CKS_TARGET) begin
            status = ST_BAD_CKS;
        end else if (first_next != expected_code(item.sent_command)) begin
            status = ST_WRONG_RSP;
        end else begin
            status = ST_OK;
        end

        byte_item.result_kind = KIND_BYTE;
        byte_item.byte_value  = byte_val;
        byte_item.byte_index  = cur_count[6:0];
        byte_item.status      = ST_OK;
        byte_item.frame_bytes = 8'd0;
        byte_item.is_final    = 1'b0;

        verdict_item.result_kind = KIND_VERDICT;
        verdict_item.byte_value  = 8'd0;
        verdict_item.byte_index  = 7'd0;
        verdict_item.status      = status;
        verdict_item.frame_bytes = count_next;
        verdict_item.is_final    = 1'b1;

        // A byte completed by the last character goes out ahead of the verdict.
        push.first_valid  = accept && (byte_done || item.last);
        push.second_valid = accept && byte_done && item.last;
        first_result      = byte_done ? byte_item : verdict_item;
        second_result     = verdict_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_frame_reg <= 1'b0;
            colon_reg    <= 1'b0;
            pending_reg  <= 1'b0;
            held_reg     <= 4'd0;
            sum_reg      <= 8'd0;
            first_reg    <= 8'd0;
            count_reg    <= 8'd0;
            overlong_reg <= 1'b0;
        end else if (accept) begin
            in_frame_reg <= in_frame_next;
            colon_reg    <= colon_next;
            pending_reg  <= pending_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            first_reg    <= first_next;
            count_reg    <= count_next;
            overlong_reg <= overlong_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> push.first_valid)
        else $error("second result pushed without a first");

    a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |=> !in_frame_reg)
        else $error("frame still open after its last character");

    a_count_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> ({count_reg, 1'b0} <= 9'(LINE_CHARS)))
        else $error("byte count beyond line length");

endmodule

// ----- rtl/core/hrf_result_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while not stalled.
module hrf_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  hrf_pkg::push_ctl_t push,
    input  hrf_pkg::out_item_t first_result,
    input  hrf_pkg::out_item_t second_result,
    output logic               room,
    output logic               valid,
    input  logic               stall,
    output hrf_pkg::out_item_t result
);
    import hrf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    out_item_t        mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [1:0]       push_cnt;
    logic             pop;

    always_comb
    begin
        push_cnt    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
        pop         = valid && !stall;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    assign valid  = (count_reg != '0);
    assign result = mem[rd_ptr_reg];
    assign room   = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= first_result;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= second_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(push_cnt) <= CNT_W'(FIFO_DEPTH) - count_reg)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && stall) |=> (valid && $stable(result)))
        else $error("stalled result changed or dropped");

endmodule

// ----- rtl/core/hex_reply_frame_checker_unit.sv -----
// Top level of the hex reply frame checker.
// Takes one reply character per cycle. A character that completes a byte is
// answered by that byte, and the character marked last by a frame verdict
// (after the byte, if it completes one), so one character yields zero, one
// or two results. Results wait in a four-entry queue; the input stalls
// only while fewer than two queue entries are free, so with a consumer that
// takes one result per cycle the block sustains one character per cycle.
module hex_reply_frame_checker_unit #(
    parameter int LINE_CHARS = hrf_pkg::LINE_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  hrf_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output hrf_pkg::out_item_t result
);
    import hrf_pkg::*;

    logic      room;
    logic      accept;
    push_ctl_t push;
    out_item_t first_result;
    out_item_t second_result;

    assign item_stall = !room;
    assign accept     = item_valid && room;

    hrf_frame_decode #(
        .LINE_CHARS(LINE_CHARS)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .push         (push),
        .first_result (first_result),
        .second_result(second_result)
    );

    hrf_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .first_result (first_result),
        .second_result(second_result),
        .room         (room),
        .valid        (result_valid),
        .stall        (result_stall),
        .result       (result)
    );

endmodule

// ----- verif/tb_hex_reply_frame_checker_unit.sv -----
// Self-checking testbench of the hex reply frame checker with directed and random line traffic.
module tb_hex_reply_frame_checker_unit;
    import hrf_pkg::*;

    localparam int LINE_CHARS = LINE_CHARS_DEF;
    localparam int RANDOM_CHARS = 500;

    typedef logic [7:0] char_t;

    // Tracks decoded bytes and verdicts that the block owes for the characters it took.
    class reply_scoreboard;
        bit in_frame;
        bit colon_seen;
        bit nibble_pending;
        bit overlong;
        logic [3:0] held_nibble;
        logic [7:0] running_sum;
        logic [7:0] first_byte;
        logic [7:0] byte_counter;
        int line_chars;
        int errors;
        out_item_t owed_q[$];

        function new(int chars_per_line);
            line_chars = chars_per_line;
            errors = 0;
            in_frame = 0;
        endfunction

        function logic [3:0] nibble_of(char_t c);
            logic [3:0] n;
            n = 4'd0;
            if (c >= "0" && c <= "9")
            begin
                n = 4'(c - "0");
            end
            else if (c >= "a" && c <= "f")
            begin
                n = 4'(c - "a" + 10);
            end
            else if (c >= "A" && c <= "F")
            begin
                n = 4'(c - "A" + 10);
            end
            return n;
        endfunction

        function logic [7:0] reply_code_for(logic [3:0] sent);
            logic [7:0] code;
            case (sent)
                4'd1:       code = 8'd5;
                4'd3, 4'd4: code = 8'd1;
                default:    code = {4'd0, sent};
            endcase
            return code;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_char(in_item_t it);
            out_item_t r;
            logic [3:0] nib;
            logic [7:0] b;
            logic [2:0] verdict;
            int pos;
            if (!in_frame)
            begin
                in_frame = 1;
                colon_seen = (it.character == COLON_CHAR);
                nibble_pending = 0;
                held_nibble = 4'd0;
                running_sum = 8'd0;
                first_byte = 8'd0;
                byte_counter = 8'd0;
                overlong = 0;
            end
            pos = 2 * int'(byte_counter) + int'(nibble_pending);
            // Once a line runs past its limit, the rest of it is dropped.
            if (overlong || pos >= line_chars)
            begin
                overlong = 1;
            end
            else
            begin
                nib = nibble_of(it.character);
                if (!nibble_pending)
                begin
                    held_nibble = nib;
                    nibble_pending = 1;
                end
                else
                begin
                    b = {held_nibble, nib};
                    r = '0;
                    r.result_kind = KIND_BYTE;
                    r.byte_value = b;
                    r.byte_index = byte_counter[6:0];
                    owed_q.push_back(r);
                    if (byte_counter == 8'd0)
                    begin
                        first_byte = b;
                    end
                    running_sum = running_sum + b;
                    byte_counter = byte_counter + 8'd1;
                    nibble_pending = 0;
                end
            end
            if (it.last)
            begin
                if (!colon_seen)
                begin
                    verdict = ST_NO_COLON;
                end
                else if (overlong)
                begin
                    verdict = ST_OVERLONG;
                end
                else if (running_sum != CKS_TARGET)
                begin
                    verdict = ST_BAD_CKS;
                end
                else if (first_byte != reply_code_for(it.sent_command))
                begin
                    verdict = ST_WRONG_RSP;
                end
                else
                begin
                    verdict = ST_OK;
                end
                r = '0;
                r.result_kind = KIND_VERDICT;
                r.status = verdict;
                r.frame_bytes = byte_counter;
                r.is_final = 1'b1;
                owed_q.push_back(r);
                in_frame = 0;
            end
        endfunction

        function void field_match(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: result with nothing owed, expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            field_match("result_kind", 8'(want.result_kind), 8'(got.result_kind));
            field_match("byte_value", want.byte_value, got.byte_value);
            field_match("byte_index", 8'(want.byte_index), 8'(got.byte_index));
            field_match("status", 8'(want.status), 8'(got.status));
            field_match("frame_bytes", want.frame_bytes, got.frame_bytes);
            field_match("is_final", 8'(want.is_final), 8'(got.is_final));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_item_t item;
    logic result_valid;
    logic result_stall;
    out_item_t result;

    reply_scoreboard sb;
    char_t line_q[$];
    int chars_sent;
    bit tx_quiet;
    bit rx_quiet;

    hex_reply_frame_checker_unit #(
        .LINE_CHARS(LINE_CHARS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_char(in_item_t it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        item = it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        sb.note_char(it);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(logic [3:0] sent);
        in_item_t it;
        for (int i = 0; i < line_q.size(); i++)
        begin
            it.character = line_q[i];
            it.last = (i == line_q.size() - 1);
            // The command is only looked at on the last character.
            it.sent_command = it.last ? sent : 4'($urandom);
            send_char(it);
        end
        item_valid = 1'b0;
    endtask

    task automatic send_text(string s, logic [3:0] sent);
        line_q.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            line_q.push_back(s[i]);
        end
        send_line(sent);
    endtask

    function automatic char_t hex_char(logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'("0" + n);
        end
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    task automatic push_byte(logic [7:0] b);
        line_q.push_back(hex_char(b[7:4]));
        line_q.push_back(hex_char(b[3:0]));
    endtask

    // A colon and the reply code digit form byte 0; the last byte closes the sum.
    task automatic build_good_line(logic [3:0] sent, int nbytes);
        logic [7:0] code;
        logic [7:0] sum;
        logic [7:0] b;
        line_q.delete();
        line_q.push_back(COLON_CHAR);
        code = sb.reply_code_for(sent);
        line_q.push_back(hex_char(code[3:0]));
        sum = code;
        for (int i = 1; i < nbytes - 1; i++)
        begin
            b = 8'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        push_byte(CKS_TARGET - sum);
    endtask

    task automatic build_overlong_line(logic [3:0] sent);
        build_good_line(sent, LINE_CHARS / 2);
        repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom));
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge clk);
    endtask

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        rx_quiet = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 31) == 0)
            begin
                rx_quiet = !rx_quiet;
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                result_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
            sb.check_result(result);
        end
    end

    initial
    begin
        int kind;
        int lines;
        logic [3:0] sent;
        sb = new(LINE_CHARS);
        chars_sent = 0;
        tx_quiet = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_text(":550", 4'd1);
        send_text(":055", 4'd9);
        send_text(":F46", 4'd15);
        send_text(":1aBa9", 4'd4);
        send_text(":550F", 4'd1);
        send_text(":", 4'd2);
        send_text("Z", 4'd5);
        line_q = '{8'h00, 8'hFF};
        send_line(4'd7);

        // Hold the line until the block has answered everything.
        wait_drained();

        sent = 4'($urandom);
        build_overlong_line(sent);
        send_line(sent);

        lines = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                tx_quiet = !tx_quiet;
            end
            kind = $urandom_range(0, 39);
            sent = 4'($urandom);
            if (kind < 35 || kind >= 38)
            begin
                build_good_line(sent,
                                $urandom_range(2, $urandom_range(0, 7) == 0 ? 32 : 8));
            end
            if (kind >= 24 && kind < 28)
            begin
                line_q[$urandom_range(1, line_q.size() - 1)] = hex_char(4'($urandom));
            end
            else if (kind >= 28 && kind < 31)
            begin
                sent = 4'($urandom);
            end
            else if (kind >= 31 && kind < 35)
            begin
                line_q.delete();
                repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom));
                if ($urandom_range(0, 1))
                begin
                    line_q[0] = COLON_CHAR;
                end
            end
            else if (kind >= 35 && kind < 38)
            begin
                build_good_line(sent, $urandom_range(2, 8));
                line_q.push_back(8'($urandom));
            end
            else if (kind >= 38)
            begin
                build_overlong_line(sent);
            end
            send_line(sent);
            lines++;
            if (lines % 40 == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d results owed but never delivered", $time, sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hrf_pkg.sv
rtl/core/hrf_frame_decode.sv
rtl/core/hrf_result_fifo.sv
rtl/core/hex_reply_frame_checker_unit.sv
verif/tb_hex_reply_frame_checker_unit.sv
